@@ hdl/afs_pkg.sv @@
// Shared types and constants for the animation frame sequencer.
package afs_pkg;

  localparam int MAX_FRAMES  = 256;
  localparam int TIME_BITS   = 32;
  localparam int FRAME_BITS  = 8;
  localparam int FCNT_BITS   = 9;
  localparam int MS_BITS     = 16;
  localparam int ACC_BITS    = 17;
  localparam int DIV_STEPS   = ACC_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_PLAY  = 2'd1;
  localparam logic [1:0] OP_PAUSE = 2'd2;
  localparam logic [1:0] OP_SET   = 2'd3;

  localparam logic [1:0] RUN_PAUSE = 2'd0;
  localparam logic [1:0] RUN_PLAY  = 2'd1;
  localparam logic [1:0] RUN_COOL  = 2'd2;
  localparam logic [1:0] RUN_END   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_MS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_PLAYING = 3'd4;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [MS_BITS-1:0]   delta_ms;
    logic [TIME_BITS-1:0] now_ms;
    logic [FRAME_BITS-1:0] frame_number;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] shown_frame;
    logic [FRAME_BITS-1:0] current_frame;
    logic [1:0]            run_state;
  } out_item_t;

  typedef struct packed {
    logic                start;
    logic [ACC_BITS-1:0] dividend;
    logic [MS_BITS-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic                busy;
    logic [ACC_BITS-1:0] quotient;
    logic [MS_BITS-1:0]  remainder;
  } div_res_t;

endpackage

@@ hdl/animation_frame_sequencer_unit.sv @@
// Top level of the animation frame sequencer: control sequencer, state and output register.
//
// Usage:
//   Configuration: cfg_we writes cfg_wdata into register cfg_index (0 frame_count,
//   1 interval_ms, 2 loop_enable, 3 cooldown_ms, 4 start_playing).
//   Write only while the block is idle. A start_playing write before the first
//   transaction after reset also sets the run state to play or pause.
//   Input channel in_valid/in_ready/in_data carries one command per transaction:
//   tick, play, pause or set frame. Every command gives exactly one result on the
//   out_valid/out_ready/out_data channel.
//   Timing: one command at a time. A tick in play runs the accumulator through a
//   bit-serial divider, 17 steps, and passes S_DECODE, S_DIV and S_FIN; any other
//   command passes S_DECODE and S_FIN. out_valid is registered on leaving S_FIN,
//   and in_ready returns with out_valid. The divider sets the rate of ticks in play.
//   Stall: a result waits in the output register while out_ready is low; the
//   next command may be accepted meanwhile, and its result is held back until
//   the register is free.
//   Reset: rst_n is synchronous, active low. Registers return to their defaults,
//   the run state to pause, the frame index and accumulator to zero.
module animation_frame_sequencer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  afs_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output afs_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [afs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import afs_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DECODE, S_DIV, S_FIN} state_t;

  state_t                state_r;
  in_item_t              item_r;
  out_item_t             out_data_r;
  logic                  out_valid_r;
  logic                  fresh_r;

  logic [FCNT_BITS-1:0]  frame_count_r;
  logic [MS_BITS-1:0]    interval_r;
  logic                  loop_r;
  logic [MS_BITS-1:0]    cooldown_r;

  logic [1:0]            mode_r, mode_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [ACC_BITS-1:0]   accum_r, accum_nxt;
  logic [TIME_BITS-1:0]  deadline_r, deadline_nxt;
  logic                  was_set_r, was_set_nxt;
  logic [ACC_BITS-1:0]   quo_r;
  logic [MS_BITS-1:0]    rem_r;

  logic [FRAME_BITS-1:0] shown;
  logic [FCNT_BITS-1:0]  fc_eff;
  logic [FRAME_BITS-1:0] last;
  logic [ACC_BITS:0]     idx;
  logic [ACC_BITS-1:0]   sum;
  logic                  div_needed;
  logic                  out_free;
  logic                  in_acc;
  div_req_t              div_req;
  div_res_t              div_res;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign sum      = accum_r + ACC_BITS'(item_r.delta_ms);
  assign div_needed = (item_r.opcode == OP_TICK) && (mode_r == RUN_PLAY);

  assign div_req.start    = (state_r == S_DECODE) && div_needed;
  assign div_req.dividend = sum;
  assign div_req.divisor  = (interval_r == '0) ? MS_BITS'(1) : interval_r;

  afs_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .res (div_res)
  );

  always_comb begin
    fc_eff = frame_count_r;
    if (fc_eff == '0) begin
      fc_eff = FCNT_BITS'(1);
    end else if (fc_eff > FCNT_BITS'(MAX_FRAMES)) begin
      fc_eff = FCNT_BITS'(MAX_FRAMES);
    end
    last = FRAME_BITS'(fc_eff - FCNT_BITS'(1));
  end

  assign idx = (ACC_BITS + 1)'(frame_r) + (ACC_BITS + 1)'(quo_r);

  always_comb begin
    mode_nxt     = mode_r;
    frame_nxt    = frame_r;
    accum_nxt    = accum_r;
    deadline_nxt = deadline_r;
    was_set_nxt  = was_set_r;
    shown        = '0;
    unique case (item_r.opcode)
      OP_TICK: begin
        shown = frame_r;
        if (mode_r == RUN_COOL) begin
          if (item_r.now_ms >= deadline_r) begin
            if (!was_set_r) begin
              frame_nxt = '0;
            end
            was_set_nxt = 1'b0;
            mode_nxt    = RUN_PLAY;
          end
        end else if (mode_r == RUN_PLAY && quo_r != '0) begin
          accum_nxt = ACC_BITS'(rem_r);
          if (idx > (ACC_BITS + 1)'(last)) begin
            if (loop_r) begin
              if (cooldown_r == '0) begin
                frame_nxt = '0;
              end else begin
                frame_nxt    = last;
                deadline_nxt = item_r.now_ms + TIME_BITS'(cooldown_r);
                mode_nxt     = RUN_COOL;
              end
            end else begin
              frame_nxt = last;
              mode_nxt  = RUN_END;
            end
          end else begin
            frame_nxt = idx[FRAME_BITS-1:0];
          end
        end
      end
      OP_PLAY: begin
        if (mode_r != RUN_PLAY) begin
          if (mode_r == RUN_END || mode_r == RUN_COOL) begin
            if (!was_set_r) begin
              frame_nxt = '0;
            end
            was_set_nxt = 1'b0;
          end
          mode_nxt = RUN_PLAY;
        end
      end
      OP_PAUSE: begin
        if (mode_r == RUN_PLAY || mode_r == RUN_COOL) begin
          mode_nxt = RUN_PAUSE;
        end
      end
      OP_SET: begin
        frame_nxt = (item_r.frame_number > last) ? last : item_r.frame_number;
        if (mode_r == RUN_END || mode_r == RUN_COOL) begin
          was_set_nxt = 1'b1;
        end
      end
      default: begin
        mode_nxt = mode_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      fresh_r         <= 1'b1;
      frame_count_r   <= FCNT_BITS'(1);
      interval_r      <= MS_BITS'(100);
      loop_r          <= 1'b0;
      cooldown_r      <= '0;
      mode_r          <= RUN_PAUSE;
      frame_r         <= '0;
      accum_r         <= '0;
      deadline_r      <= '0;
      was_set_r       <= 1'b0;
    end else begin
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_COUNT:   frame_count_r <= cfg_wdata[FCNT_BITS-1:0];
          REG_INTERVAL_MS:   interval_r    <= cfg_wdata[MS_BITS-1:0];
          REG_LOOP_ENABLE:   loop_r        <= cfg_wdata[0];
          REG_COOLDOWN_MS:   cooldown_r    <= cfg_wdata[MS_BITS-1:0];
          REG_START_PLAYING: begin
            if (fresh_r) begin
              mode_r <= cfg_wdata[0] ? RUN_PLAY : RUN_PAUSE;
            end
          end
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            fresh_r <= 1'b0;
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (div_needed) begin
            accum_r <= sum;
            state_r <= S_DIV;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            mode_r      <= mode_nxt;
            frame_r     <= frame_nxt;
            accum_r     <= accum_nxt;
            deadline_r  <= deadline_nxt;
            was_set_r   <= was_set_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
    if (state_r == S_DIV && div_res.done) begin
      quo_r <= div_res.quotient;
      rem_r <= div_res.remainder;
    end
    if (state_r == S_DECODE && !div_needed) begin
      quo_r <= '0;
    end
    if (state_r == S_FIN && out_free) begin
      out_data_r.shown_frame   <= shown;
      out_data_r.current_frame <= frame_nxt;
      out_data_r.run_state     <= mode_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input accepted again before the transaction finished");

  a_fin_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (out_valid && state_r == S_IDLE))
    else $error("finished transaction did not reach the output register");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_res.busy)
    else $error("divider started while busy");

endmodule

@@ hdl/afs_div.sv @@
// Restoring divider, one quotient bit per cycle, for the time accumulator.
module afs_div (
  input  logic            clk,
  input  logic            rst_n,
  input  afs_pkg::div_req_t req,
  output afs_pkg::div_res_t res
);
  import afs_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [ACC_BITS-1:0]  quo_r;
  logic [MS_BITS-1:0]   rem_r;
  logic [MS_BITS-1:0]   dvs_r;

  logic [ACC_BITS-1:0]  shifted;
  logic [ACC_BITS:0]    diff;
  logic                 fits;

  assign shifted = {rem_r, quo_r[ACC_BITS-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign fits    = ~diff[ACC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[MS_BITS-1:0] : shifted[MS_BITS-1:0];
      quo_r <= {quo_r[ACC_BITS-2:0], fits};
    end
  end

  assign res.done      = done_r;
  assign res.busy      = busy_r;
  assign res.quotient  = quo_r;
  assign res.remainder = rem_r;

endmodule

@@ test/afs_frame_checker.sv @@
`timescale 1ns / 1ps
// Checker for the animation frame sequencer: tracks its state and compares every result.
module afs_frame_checker
  import afs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    checked
);

  logic [FCNT_BITS-1:0]  frame_count_q;
  logic [MS_BITS-1:0]    interval_q;
  logic                  loop_q;
  logic [MS_BITS-1:0]    cooldown_q;

  logic [1:0]            run_q;
  logic [FRAME_BITS-1:0] pos_q;
  logic [ACC_BITS-1:0]   accum_q;
  logic [TIME_BITS-1:0]  deadline_q;
  logic                  set_mark_q;
  logic                  fresh_q;

  out_item_t expected_frames[$];
  int fails = 0;
  int results_checked = 0;

  function automatic logic [FRAME_BITS-1:0] last_frame_of(input logic [FCNT_BITS-1:0] n);
    logic [FCNT_BITS-1:0] c;
    c = n;
    if (c == '0) c = FCNT_BITS'(1);
    if (c > FCNT_BITS'(MAX_FRAMES)) c = FCNT_BITS'(MAX_FRAMES);
    return FRAME_BITS'(c - FCNT_BITS'(1));
  endfunction

  task automatic resume_play();
    if (run_q != RUN_PLAY) begin
      if (run_q == RUN_END || run_q == RUN_COOL) begin
        if (!set_mark_q) pos_q = '0;
        set_mark_q = 1'b0;
      end
      run_q = RUN_PLAY;
    end
  endtask

  task automatic step_frame(input in_item_t cmd, output out_item_t res);
    logic [ACC_BITS-1:0]            iv;
    logic [ACC_BITS-1:0]            q;
    logic [ACC_BITS+FRAME_BITS-1:0] idx;
    logic [FRAME_BITS-1:0]          last;
    last = last_frame_of(frame_count_q);
    res.shown_frame = '0;
    case (cmd.opcode)
      OP_TICK: begin
        res.shown_frame = pos_q;
        if (run_q == RUN_COOL) begin
          if (cmd.now_ms >= deadline_q) resume_play();
        end else if (run_q == RUN_PLAY) begin
          iv = (interval_q == '0) ? ACC_BITS'(1) : ACC_BITS'(interval_q);
          accum_q = accum_q + ACC_BITS'(cmd.delta_ms);
          q = accum_q / iv;
          if (q != '0) begin
            accum_q = accum_q % iv;
            idx = (ACC_BITS+FRAME_BITS)'(pos_q) + (ACC_BITS+FRAME_BITS)'(q);
            if (idx > (ACC_BITS+FRAME_BITS)'(last)) begin
              if (loop_q && cooldown_q == '0) begin
                pos_q = '0;
              end else if (loop_q) begin
                pos_q = last;
                deadline_q = cmd.now_ms + TIME_BITS'(cooldown_q);
                run_q = RUN_COOL;
              end else begin
                pos_q = last;
                run_q = RUN_END;
              end
            end else begin
              pos_q = idx[FRAME_BITS-1:0];
            end
          end
        end
      end
      OP_PLAY: resume_play();
      OP_PAUSE: begin
        if (run_q == RUN_PLAY || run_q == RUN_COOL) run_q = RUN_PAUSE;
      end
      OP_SET: begin
        pos_q = (cmd.frame_number > last) ? last : cmd.frame_number;
        if (run_q == RUN_END || run_q == RUN_COOL) set_mark_q = 1'b1;
      end
      default: ;
    endcase
    res.current_frame = pos_q;
    res.run_state = run_q;
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t res;
    if (!rst_n) begin
      frame_count_q = 9'd1;
      interval_q    = 16'd100;
      loop_q        = 1'b0;
      cooldown_q    = '0;
      run_q         = RUN_PAUSE;
      pos_q         = '0;
      accum_q       = '0;
      deadline_q    = '0;
      set_mark_q    = 1'b0;
      fresh_q       = 1'b1;
      expected_frames.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_COUNT: frame_count_q = cfg_wdata[FCNT_BITS-1:0];
          REG_INTERVAL_MS: interval_q = cfg_wdata[MS_BITS-1:0];
          REG_LOOP_ENABLE: loop_q = cfg_wdata[0];
          REG_COOLDOWN_MS: cooldown_q = cfg_wdata[MS_BITS-1:0];
          REG_START_PLAYING: begin
            if (fresh_q) run_q = cfg_wdata[0] ? RUN_PLAY : RUN_PAUSE;
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result: shown %0d current %0d state %0d, nothing pending",
                     out_data.shown_frame, out_data.current_frame, out_data.run_state);
        end else begin
          want = expected_frames.pop_front();
          results_checked++;
          if (out_data.shown_frame !== want.shown_frame ||
              out_data.current_frame !== want.current_frame ||
              out_data.run_state !== want.run_state) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected shown %0d current %0d state %0d, got %0d %0d %0d",
                       want.shown_frame, want.current_frame, want.run_state,
                       out_data.shown_frame, out_data.current_frame, out_data.run_state);
          end
        end
      end
      if (in_valid && in_ready) begin
        fresh_q = 1'b0;
        step_frame(in_data, res);
        expected_frames = {expected_frames, res};
      end
    end
    pending    <= expected_frames.size();
    fail_count <= fails;
    checked    <= results_checked;
  end

endmodule

@@ test/tb_animation_frame_sequencer_unit.sv @@
`timescale 1ns / 1ps
// Testbench top for the animation frame sequencer: stimulus, register settings and verdict.
module tb_animation_frame_sequencer_unit;
  import afs_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 1100;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int checked;
  int items_sent = 0;
  int settings_used = 0;
  int stall_cycles = 0;
  logic idle_en = 1'b1;
  logic [TIME_BITS-1:0] wall_ms = '0;
  logic [FCNT_BITS-1:0] cur_fc = 9'd1;
  logic [MS_BITS-1:0]   cur_iv = 16'd100;

  always #6 clk = ~clk;

  animation_frame_sequencer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  afs_frame_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always @(posedge clk) begin
    out_ready <= (idle_en && $urandom_range(0, 99) < 9) ? 1'b0 : 1'b1;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_cmd(input logic [1:0] op, input logic [MS_BITS-1:0] delta,
                          input logic [TIME_BITS-1:0] now, input logic [FRAME_BITS-1:0] fnum);
    in_item_t cmd;
    int gap;
    cmd.opcode = op;
    cmd.delta_ms = delta;
    cmd.now_ms = now;
    cmd.frame_number = fnum;
    gap = 0;
    if (idle_en) while ($urandom_range(0, 99) < 9) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_op(input logic [1:0] op);
    send_cmd(op, MS_BITS'($urandom), $urandom, FRAME_BITS'($urandom));
  endtask

  task automatic tick_for(input logic [MS_BITS-1:0] delta);
    wall_ms = wall_ms + TIME_BITS'(delta);
    send_cmd(OP_TICK, delta, wall_ms, FRAME_BITS'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [FCNT_BITS-1:0] fc, input logic [MS_BITS-1:0] iv,
                            input logic lp, input logic [MS_BITS-1:0] cd, input logic sp);
    write_reg(REG_FRAME_COUNT, CFG_DATA_W'(fc));
    write_reg(REG_INTERVAL_MS, iv);
    write_reg(REG_LOOP_ENABLE, CFG_DATA_W'(lp));
    write_reg(REG_COOLDOWN_MS, cd);
    write_reg(REG_START_PLAYING, CFG_DATA_W'(sp));
    cfg_we <= 1'b0;
    cur_fc = fc;
    cur_iv = iv;
    settings_used++;
  endtask

  initial begin
    int r;
    int n;
    int lim;
    int rnd_phase;
    int directed;
    logic [FCNT_BITS-1:0] fc;
    logic [MS_BITS-1:0]   iv;
    logic [MS_BITS-1:0]   cd;
    logic [MS_BITS-1:0]   d;
    logic [FRAME_BITS-1:0] f;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // defaults with the run state loaded before the first transaction
    write_reg(REG_START_PLAYING, '0);
    write_reg(REG_START_PLAYING, 16'd1);
    cfg_we <= 1'b0;
    settings_used++;
    send_cmd(OP_TICK, 16'd0, 32'd0, 8'hFF);
    send_cmd(OP_TICK, 16'hFFFF, 32'hFFFF_FFFF, 8'h00);
    tick_for(16'd50);
    send_cmd(OP_SET, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    send_op(OP_PLAY);
    send_op(OP_PLAY);
    send_op(OP_PAUSE);
    send_op(OP_PAUSE);
    tick_for(16'hFFFF);
    drain();

    set_config(9'd8, 16'd10, 1'b1, 16'd0, 1'b0);
    send_op(OP_PLAY);
    tick_for(16'd25);
    tick_for(16'd60);
    send_cmd(OP_SET, MS_BITS'($urandom), $urandom, 8'hFF);
    tick_for(16'd10);
    drain();

    set_config(9'd4, 16'd5, 1'b1, 16'd30, 1'b0);
    tick_for(16'd20);
    send_cmd(OP_SET, MS_BITS'($urandom), $urandom, 8'd2);
    send_cmd(OP_TICK, 16'd0, wall_ms, FRAME_BITS'($urandom));
    send_cmd(OP_TICK, 16'd0, 32'hFFFF_FFFF, FRAME_BITS'($urandom));
    tick_for(16'd20);
    send_op(OP_PAUSE);
    drain();

    set_config(9'd256, 16'd1, 1'b0, 16'hFFFF, 1'b1);
    send_op(OP_PLAY);
    send_cmd(OP_SET, MS_BITS'($urandom), $urandom, 8'd200);
    tick_for(16'd10);
    drain();

    // lower the frame count below the index that is held
    set_config(9'd3, 16'd0, 1'b0, 16'd0, 1'b0);
    tick_for(16'd0);
    tick_for(16'd5);
    drain();

    set_config(9'd511, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1);
    send_op(OP_PLAY);
    tick_for(16'hFFFF);
    tick_for(16'hFFFF);
    directed = items_sent;

    rnd_phase = 0;
    while (items_sent < directed + RANDOM_ITEMS) begin
      drain();
      r = $urandom_range(0, 99);
      if (r < 65) fc = FCNT_BITS'($urandom_range(1, 12));
      else if (r < 75) fc = 9'd0;
      else if (r < 85) fc = 9'd256;
      else fc = FCNT_BITS'($urandom_range(13, 511));
      r = $urandom_range(0, 99);
      if (r < 50) iv = MS_BITS'($urandom_range(1, 20));
      else if (r < 60) iv = 16'd0;
      else if (r < 70) iv = 16'd1;
      else if (r < 85) iv = MS_BITS'($urandom_range(21, 2000));
      else if (r < 92) iv = 16'hFFFF;
      else iv = MS_BITS'($urandom_range(2001, 65535));
      r = $urandom_range(0, 99);
      if (r < 40) cd = 16'd0;
      else if (r < 85) cd = MS_BITS'($urandom_range(1, 300));
      else cd = MS_BITS'($urandom);
      set_config(fc, iv, $urandom_range(0, 3) != 0, cd, 1'($urandom_range(0, 1)));
      idle_en <= !(rnd_phase == 2 || rnd_phase == 3);
      rnd_phase++;
      n = $urandom_range(50, 120);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 68) begin
          lim = 2 * ((cur_iv == '0) ? 1 : int'(cur_iv)) + 1;
          if (lim > 65535) lim = 65535;
          r = $urandom_range(0, 99);
          if (r < 10) d = 16'd0;
          else if (r < 18) d = 16'hFFFF;
          else if (r < 35) d = MS_BITS'($urandom);
          else d = MS_BITS'($urandom_range(0, lim));
          if ($urandom_range(0, 9) == 0) wall_ms = $urandom;
          else wall_ms = wall_ms + TIME_BITS'(d);
          send_cmd(OP_TICK, d, wall_ms, FRAME_BITS'($urandom));
        end else if (r < 78) begin
          send_op(OP_PLAY);
        end else if (r < 86) begin
          send_op(OP_PAUSE);
        end else begin
          lim = int'(cur_fc) + 2;
          if (lim > 255) lim = 255;
          if ($urandom_range(0, 1) == 0) f = FRAME_BITS'($urandom_range(0, lim));
          else f = FRAME_BITS'($urandom_range(0, 255));
          send_cmd(OP_SET, MS_BITS'($urandom), $urandom, f);
        end
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Summary: %0d commands (%0d directed) over %0d register settings",
             items_sent, directed, settings_used);
    $display("Summary: %0d results compared, %0d failures", checked, fail_count);
    if (fail_count == 0 && pending == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/afs_pkg.sv
hdl/afs_div.sv
hdl/animation_frame_sequencer_unit.sv
test/afs_frame_checker.sv
test/tb_animation_frame_sequencer_unit.sv
